// File: sv/cst_pkg.sv
// Shared constants and types for the coordinate set table.
package cst_pkg;

  localparam int DEPTH   = 64;
  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int KIND_W  = 2;
  localparam int COORD_W = 16;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  typedef logic [KIND_W-1:0]         kind_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic [COUNT_W-1:0]        count_t;

  localparam kind_t KIND_ADD  = 2'd0;
  localparam kind_t KIND_DEL  = 2'd1;
  localparam kind_t KIND_HAS  = 2'd2;
  localparam kind_t KIND_READ = 2'd3;

  typedef struct packed {
    logic load;
    logic lookup;
    logic commit;
  } cmd_t;

endpackage

// File: sv/cst_if.sv
// Valid/ready channel interfaces for operation beats and result beats.
interface cst_in_if;
  import cst_pkg::*;

  logic   valid;
  logic   ready;
  kind_t  kind;
  coord_t pos_x;
  coord_t pos_y;
  index_t index;

  modport source (output valid, output kind, output pos_x, output pos_y, output index,
                  input ready);
  modport sink (input valid, input kind, input pos_x, input pos_y, input index,
                output ready);
endinterface

interface cst_out_if;
  import cst_pkg::*;

  logic   valid;
  logic   ready;
  logic   hit;
  logic   full_res;
  count_t count;
  coord_t read_x;
  coord_t read_y;

  modport source (output valid, output hit, output full_res, output count,
                  output read_x, output read_y, input ready);
  modport sink (input valid, input hit, input full_res, input count,
                input read_x, input read_y, output ready);
endinterface

// File: sv/cst_ctrl.sv
// Sequencer for the coordinate set table: load, lookup, commit.
module cst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cst_pkg::cmd_t cmd
);
  import cst_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_EXEC   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       commit;
  logic       accept;

  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == ST_EXEC) && out_free;
  assign in_ready = (state_r == ST_IDLE) || commit;
  assign accept   = in_valid && in_ready;

  assign cmd.load   = accept;
  assign cmd.lookup = (state_r == ST_LOOKUP);
  assign cmd.commit = commit;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (commit) state_nxt = accept ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/cst_dp.sv
// Datapath: entry registers with match lanes, shadow RAM, live count, result register.
module cst_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  cst_pkg::cmd_t  cmd,
  input  cst_pkg::kind_t in_kind,
  input  cst_pkg::coord_t in_pos_x,
  input  cst_pkg::coord_t in_pos_y,
  input  cst_pkg::index_t in_index,
  output logic           out_hit,
  output logic           out_full_res,
  output cst_pkg::count_t out_count,
  output cst_pkg::coord_t out_read_x,
  output cst_pkg::coord_t out_read_y
);
  import cst_pkg::*;

  kind_t  kind_r;
  coord_t px_r, py_r;
  index_t idx_r;

  coord_t ent_x_r [DEPTH];
  coord_t ent_y_r [DEPTH];
  coord_t mem_x [DEPTH];
  coord_t mem_y [DEPTH];

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DEPTH-1:0]  eq;
  logic [SLOT_W-1:0] slot_enc, slot_r;
  logic              found_r;
  logic [SLOT_W-1:0] raddr;
  coord_t            rd_x_r, rd_y_r;

  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  coord_t            wr_x, wr_y;
  logic              hit, full;
  coord_t            rx, ry;

  logic              out_hit_r, out_full_r;
  count_t            out_count_r;
  coord_t            out_x_r, out_y_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      idx_r  <= in_index;
    end
  end

  always_comb begin
    eq       = '0;
    slot_enc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      eq[i] = (CNT_W'(i) < count_r) && (ent_x_r[i] == px_r) && (ent_y_r[i] == py_r);
      if (eq[i]) slot_enc = slot_enc | SLOT_W'(i);
    end
  end

  assign raddr = (kind_r == KIND_READ) ? SLOT_W'(idx_r) : SLOT_W'(count_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      found_r <= |eq;
      slot_r  <= slot_enc;
      rd_x_r  <= mem_x[raddr];
      rd_y_r  <= mem_y[raddr];
    end
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_x      = px_r;
    wr_y      = py_r;
    hit       = 1'b0;
    full      = 1'b0;
    rx        = '0;
    ry        = '0;
    count_nxt = count_r;
    case (kind_r)
      KIND_ADD: begin
        if (!found_r) begin
          if (count_r == CNT_W'(DEPTH)) begin
            full = 1'b1;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = SLOT_W'(count_r);
            hit       = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      KIND_DEL: begin
        if (found_r) begin
          wr_en     = 1'b1;
          wr_addr   = slot_r;
          wr_x      = rd_x_r;
          wr_y      = rd_y_r;
          hit       = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      KIND_HAS: begin
        hit = found_r;
      end
      KIND_READ: begin
        if (32'(idx_r) < 32'(count_r)) begin
          hit = 1'b1;
          rx  = rd_x_r;
          ry  = rd_y_r;
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      ent_x_r[wr_addr] <= wr_x;
      ent_y_r[wr_addr] <= wr_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r   <= hit;
      out_full_r  <= full;
      out_count_r <= COUNT_W'(count_nxt);
      out_x_r     <= rx;
      out_y_r     <= ry;
    end
  end

  assign out_hit      = out_hit_r;
  assign out_full_res = out_full_r;
  assign out_count    = out_count_r;
  assign out_read_x   = out_x_r;
  assign out_read_y   = out_y_r;

endmodule

// File: sv/coordinate_set_table_unit.sv
// Top level of the coordinate set table: sequencer, datapath and checks.
//
// Keeps a set of distinct (x,y) positions in DEPTH slots with a live count.
// in_ch carries one operation per beat: add, delete, contains, or read at index.
// out_ch returns one result beat per operation: hit, full_res, count, read_x, read_y.
// After acceptance an operation passes through lookup and execute: a lookup cycle compares the
// position against every live entry in parallel and reads the shadow RAM (the
// last entry for delete, the indexed slot for read); an execute cycle writes
// the new or swapped-in entry, updates the count and loads the result register.
// out_ch.valid is registered and rises after the execute cycle that commits.
// A new operation is accepted only while idle or in the committing execute cycle,
// as the lookup/execute pair shares the one compare array and the one RAM read port.
// Reset clears the live count and the result valid; entries need no clearing.
// When out_ch stalls, the held result stays in the output register, one more
// operation is accepted and waits in execute without writing until the
// output register frees; in_ch.ready stays low meanwhile.
module coordinate_set_table_unit (
  input logic       clk,
  input logic       rst_n,
  cst_in_if.sink    in_ch,
  cst_out_if.source out_ch
);
  import cst_pkg::*;

  cmd_t cmd;
  logic in_ready;
  logic out_valid;

  cst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  cst_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_kind      (in_ch.kind),
    .in_pos_x     (in_ch.pos_x),
    .in_pos_y     (in_ch.pos_y),
    .in_index     (in_ch.index),
    .out_hit      (out_ch.hit),
    .out_full_res (out_ch.full_res),
    .out_count    (out_ch.count),
    .out_read_x   (out_ch.read_x),
    .out_read_y   (out_ch.read_y)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.full_res && out_ch.hit))
    else $error("full_res and hit both set");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (32'(out_ch.count) <= DEPTH))
    else $error("count exceeds table depth");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.hit) |-> (out_ch.read_x == '0 && out_ch.read_y == '0))
    else $error("read data nonzero without hit");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid)
    else $error("commit did not present a result beat");

  a_lookup_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.lookup)
    else $error("accepted beat not followed by lookup");

endmodule
